// ===== hw/rtl/sedfr_pkg.sv =====
// shared types, codes and reset values for the framed byte receiver
package sedfr_pkg;

    // default frame capacity in bytes
    localparam int FRAME_LEN_DEF = 64;

    // configuration register indexes
    localparam int          CFG_IDX_W       = 3;
    localparam logic [2:0]  CFG_CRC_POLY    = 3'd0;
    localparam logic [2:0]  CFG_CRC_INIT    = 3'd1;
    localparam logic [2:0]  CFG_START_CODE  = 3'd2;
    localparam logic [2:0]  CFG_END_CODE    = 3'd3;
    localparam logic [2:0]  CFG_ESCAPE_CODE = 3'd4;

    // configuration reset values
    localparam logic [15:0] CRC_POLY_RST    = 16'h1021;
    localparam logic [15:0] CRC_INIT_RST    = 16'hFFFF;
    localparam logic [7:0]  START_CODE_RST  = 8'h02;
    localparam logic [7:0]  END_CODE_RST    = 8'h03;
    localparam logic [7:0]  ESCAPE_CODE_RST = 8'h10;

    // parser states
    localparam logic [1:0] ST_WAIT    = 2'd0;
    localparam logic [1:0] ST_CLEAR   = 2'd1;
    localparam logic [1:0] ST_UNESC   = 2'd2;
    localparam logic [1:0] ST_COLLECT = 2'd3;

    // result event codes
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_PAYLOAD  = 3'd1;
    localparam logic [2:0] EV_GOOD     = 3'd2;
    localparam logic [2:0] EV_CRCERR   = 3'd3;
    localparam logic [2:0] EV_OVERFLOW = 3'd4;
    localparam logic [2:0] EV_HALT     = 3'd5;

    // input beat
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       upstream_error;
    } in_beat_t;

    // result beat
    typedef struct packed {
        logic [2:0] event_kind;
        logic [7:0] payload_byte;
        logic [5:0] payload_index;
        logic [6:0] frame_length;
        logic       crc_error_seen;
        logic       overflow_seen;
    } out_beat_t;

    // configuration register set
    typedef struct packed {
        logic [15:0] crc_poly;
        logic [15:0] crc_init;
        logic [7:0]  start_code;
        logic [7:0]  end_code;
        logic [7:0]  escape_code;
    } cfg_regs_t;

endpackage

// ===== hw/rtl/sedfr_cfg.sv =====
// configuration register file of the framed byte receiver
module sedfr_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            wr_en,
    input  logic [sedfr_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [15:0]                     wr_data,
    output sedfr_pkg::cfg_regs_t            cfg
);
    import sedfr_pkg::*;

    cfg_regs_t cfg_reg;
    cfg_regs_t cfg_next;

    // register select, unknown indexes leave everything unchanged
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_index)
                CFG_CRC_POLY:    cfg_next.crc_poly    = wr_data;
                CFG_CRC_INIT:    cfg_next.crc_init    = wr_data;
                CFG_START_CODE:  cfg_next.start_code  = wr_data[7:0];
                CFG_END_CODE:    cfg_next.end_code    = wr_data[7:0];
                CFG_ESCAPE_CODE: cfg_next.escape_code = wr_data[7:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.crc_poly    <= CRC_POLY_RST;
            cfg_reg.crc_init    <= CRC_INIT_RST;
            cfg_reg.start_code  <= START_CODE_RST;
            cfg_reg.end_code    <= END_CODE_RST;
            cfg_reg.escape_code <= ESCAPE_CODE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/sedfr_crc8.sv =====
// byte-wide crc-16 update, msb first, no reflection
module sedfr_crc8 (
    input  logic [15:0] crc_in,
    input  logic [7:0]  data_in,
    input  logic [15:0] poly_in,
    output logic [15:0] crc_out
);
    logic [15:0] acc;

    // eight shift steps unrolled
    always_comb begin
        acc = crc_in ^ {data_in, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (acc[15]) begin
                acc = {acc[14:0], 1'b0} ^ poly_in;
            end else begin
                acc = {acc[14:0], 1'b0};
            end
        end
        crc_out = acc;
    end

endmodule

// ===== hw/rtl/sedfr_core.sv =====
// deframing state machine with byte count, crc and sticky flags
module sedfr_core #(
    parameter int FRAME_LEN = sedfr_pkg::FRAME_LEN_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  sedfr_pkg::in_beat_t  beat_in,
    input  sedfr_pkg::cfg_regs_t cfg,
    output sedfr_pkg::out_beat_t beat_out
);
    import sedfr_pkg::*;

    localparam int CNT_W = $clog2(FRAME_LEN + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(FRAME_LEN);

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [15:0]      crc_reg, crc_next;
    logic             ovf_reg, ovf_next;
    logic             crcfail_reg, crcfail_next;

    logic [CNT_W-1:0] count_base;
    logic [15:0]      crc_base;
    logic [15:0]      crc_folded;
    logic [7:0]       b;
    out_beat_t        res;

    assign b = beat_in.rx_byte;

    // the clear state restarts the frame before looking at its byte
    assign count_base = (state_reg == ST_CLEAR) ? '0 : count_reg;
    assign crc_base   = (state_reg == ST_CLEAR) ? cfg.crc_init : crc_reg;

    sedfr_crc8 u_crc8 (
        .crc_in  (crc_base),
        .data_in (b),
        .poly_in (cfg.crc_poly),
        .crc_out (crc_folded)
    );

    // next state and result
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        crc_next     = crc_reg;
        ovf_next     = ovf_reg;
        crcfail_next = crcfail_reg;
        res          = '0;

        if (ovf_reg) begin
            res.event_kind = EV_HALT;
        end else if (beat_in.upstream_error) begin
            state_next     = ST_WAIT;
            count_next     = '0;
            crc_next       = cfg.crc_init;
            res.event_kind = EV_HALT;
        end else begin
            count_next = count_base;
            crc_next   = crc_base;
            case (state_reg)
                ST_WAIT: begin
                    if (b == cfg.start_code) state_next = ST_CLEAR;
                end
                ST_CLEAR, ST_UNESC, ST_COLLECT: begin
                    if (state_reg != ST_UNESC && state_reg != ST_COLLECT
                            && b == cfg.start_code) begin
                        state_next = ST_CLEAR;
                    end else if (state_reg == ST_CLEAR && b == cfg.end_code) begin
                        state_next = ST_WAIT;
                    end else if (state_reg != ST_UNESC && b == cfg.escape_code) begin
                        state_next = ST_UNESC;
                    end else if (state_reg == ST_COLLECT && b == cfg.start_code) begin
                        state_next = ST_CLEAR;
                    end else if (state_reg == ST_COLLECT && b == cfg.end_code) begin
                        // frame end, residue check
                        state_next       = ST_WAIT;
                        res.frame_length = 7'(count_base);
                        if (crc_base == 16'h0000) begin
                            res.event_kind = EV_GOOD;
                        end else begin
                            crcfail_next   = 1'b1;
                            res.event_kind = EV_CRCERR;
                        end
                    end else begin
                        // store a payload byte
                        state_next = ST_COLLECT;
                        if (count_base < CNT_MAX) begin
                            res.event_kind    = EV_PAYLOAD;
                            res.payload_byte  = b;
                            res.payload_index = 6'(count_base);
                            count_next        = count_base + 1'b1;
                            crc_next          = crc_folded;
                        end else begin
                            ovf_next       = 1'b1;
                            res.event_kind = EV_OVERFLOW;
                        end
                    end
                end
                default: state_next = ST_WAIT;
            endcase
        end

        res.crc_error_seen = crcfail_next;
        res.overflow_seen  = ovf_next;
    end

    // state registers, updated once per processed beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_WAIT;
            count_reg   <= '0;
            crc_reg     <= CRC_INIT_RST;
            ovf_reg     <= 1'b0;
            crcfail_reg <= 1'b0;
        end else if (step) begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            crc_reg     <= crc_next;
            ovf_reg     <= ovf_next;
            crcfail_reg <= crcfail_next;
        end
    end

    assign beat_out = res;

endmodule

// ===== hw/rtl/stx_etx_dle_frame_receiver_crc.sv =====
// top level of the framed byte receiver with crc-16 check
//
// channel   direction  handshake            payload
// s_        in         s_valid / s_ready    s_data     (rx_byte, upstream_error)
// m_        out        m_valid / m_ready    m_data     (event, payload, length, flags)
// cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one result beat per input beat; a beat taken on s_ passes the input register, then the result register, to m_
// sustained rate is one beat per cycle while m_ready stays high: input register, parser logic, result register
// synchronous active-low reset; parser waits for start, crc holds its initial value
// a stall on m_ fills the input register, then drops s_ready; no beat is lost
// cfg_ready is always high; writes take effect on the next beat processed
module stx_etx_dle_frame_receiver_crc #(
    parameter int FRAME_LEN = sedfr_pkg::FRAME_LEN_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  sedfr_pkg::in_beat_t             s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output sedfr_pkg::out_beat_t            m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sedfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                     cfg_data
);
    import sedfr_pkg::*;

    logic      in_valid_reg;
    in_beat_t  in_data_reg;
    logic      out_valid_reg;
    out_beat_t out_data_reg;
    logic      out_free;
    logic      step;
    cfg_regs_t cfg;
    out_beat_t core_res;

    assign cfg_ready = 1'b1;

    sedfr_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // pipeline flow control
    assign out_free = !out_valid_reg || m_ready;
    assign step     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || step;

    sedfr_core #(
        .FRAME_LEN (FRAME_LEN)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .beat_in  (in_data_reg),
        .cfg      (cfg),
        .beat_out (core_res)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= step;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_data_reg <= core_res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // checks
    a_ovf_event_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg.event_kind == EV_OVERFLOW
            |-> out_data_reg.overflow_seen)
        else $error("overflow event without sticky overflow flag");

    a_crc_event_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg.event_kind == EV_CRCERR
            |-> out_data_reg.crc_error_seen)
        else $error("crc error event without sticky crc flag");

    a_no_payload_halted: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg.event_kind == EV_PAYLOAD
            |-> !out_data_reg.overflow_seen)
        else $error("payload beat reported while halted");

    a_stall_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_free |-> !s_ready)
        else $error("input taken while both stages are full");

endmodule

// ===== verif/tb_stx_etx_dle_frame_receiver_crc.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the stx/etx/dle frame receiver with crc-16 check
module tb_stx_etx_dle_frame_receiver_crc;
    import sedfr_pkg::*;

    localparam int FRAME_LEN  = FRAME_LEN_DEF;
    localparam int WATCHDOG   = 4000;
    localparam int RAND_ITEMS = 120;
    // index past the end of the register map, must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

    // which side of the link is slow
    typedef enum logic [1:0] {PACE_SLOW_RX, PACE_SLOW_TX, PACE_FULL} pace_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_beat_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_beat_t            m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data  = '0;

    pace_t pace = PACE_SLOW_RX;
    wire [6:0] send_gap_pct = (pace == PACE_SLOW_TX) ? 7'd80 :
                              (pace == PACE_SLOW_RX) ? 7'd11 : 7'd0;
    wire [6:0] recv_gap_pct = (pace == PACE_SLOW_RX) ? 7'd80 :
                              (pace == PACE_SLOW_TX) ? 7'd11 : 7'd0;

    // register values as last written
    cfg_regs_t regs_now = {CRC_POLY_RST, CRC_INIT_RST, START_CODE_RST, END_CODE_RST,
                           ESCAPE_CODE_RST};

    // deframer state mirrored on the testbench side
    logic [1:0]  rx_state  = ST_WAIT;
    logic [6:0]  frame_cnt = '0;
    logic [15:0] crc_acc   = CRC_INIT_RST;
    logic        halted    = 1'b0;
    logic        crc_bad   = 1'b0;

    in_beat_t    rx_backlog[$];
    out_beat_t   events_due[$];
    logic [7:0]  frame_body[$];
    int          items_queued = 0;
    int          err_count    = 0;
    int          stall_cycles = 0;

    stx_etx_dle_frame_receiver_crc dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // crc-16, msb first, one byte
    function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] d,
                                               input logic [15:0] poly);
        logic [15:0] c;
        c = acc ^ {d, 8'h00};
        for (int i = 0; i < 8; i++)
            c = c[15] ? ((c << 1) ^ poly) : (c << 1);
        return c;
    endfunction

    // store one payload byte or flag overflow on a full frame
    function automatic out_beat_t store_payload(input out_beat_t r, input logic [7:0] d);
        out_beat_t o;
        o = r;
        if (frame_cnt < FRAME_LEN) begin
            o.event_kind    = EV_PAYLOAD;
            o.payload_byte  = d;
            o.payload_index = frame_cnt[5:0];
            frame_cnt       = frame_cnt + 7'd1;
            crc_acc         = crc16_fold(crc_acc, d, regs_now.crc_poly);
        end else begin
            halted       = 1'b1;
            o.event_kind = EV_OVERFLOW;
        end
        return o;
    endfunction

    // expected result of one received byte, advances the mirrored state
    function automatic out_beat_t deframe_beat(input in_beat_t b);
        out_beat_t r;
        r = '0;
        if (halted) begin
            r.event_kind = EV_HALT;
        end else if (b.upstream_error) begin
            rx_state     = ST_WAIT;
            frame_cnt    = '0;
            crc_acc      = regs_now.crc_init;
            r.event_kind = EV_HALT;
        end else begin
            case (rx_state)
                ST_WAIT: begin
                    if (b.rx_byte == regs_now.start_code)
                        rx_state = ST_CLEAR;
                end
                ST_CLEAR: begin
                    frame_cnt = '0;
                    crc_acc   = regs_now.crc_init;
                    if (b.rx_byte == regs_now.start_code) begin
                        rx_state = ST_CLEAR;
                    end else if (b.rx_byte == regs_now.end_code) begin
                        rx_state = ST_WAIT;
                    end else if (b.rx_byte == regs_now.escape_code) begin
                        rx_state = ST_UNESC;
                    end else begin
                        r        = store_payload(r, b.rx_byte);
                        rx_state = ST_COLLECT;
                    end
                end
                ST_UNESC: begin
                    r        = store_payload(r, b.rx_byte);
                    rx_state = ST_COLLECT;
                end
                default: begin
                    if (b.rx_byte == regs_now.escape_code) begin
                        rx_state = ST_UNESC;
                    end else if (b.rx_byte == regs_now.start_code) begin
                        rx_state = ST_CLEAR;
                    end else if (b.rx_byte == regs_now.end_code) begin
                        rx_state       = ST_WAIT;
                        r.frame_length = frame_cnt;
                        if (crc_acc == 16'h0000) begin
                            r.event_kind = EV_GOOD;
                        end else begin
                            crc_bad      = 1'b1;
                            r.event_kind = EV_CRCERR;
                        end
                    end else begin
                        r = store_payload(r, b.rx_byte);
                    end
                end
            endcase
        end
        r.crc_error_seen = crc_bad;
        r.overflow_seen  = halted;
        return r;
    endfunction

    // byte source: beats come from the backlog, expectations made on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                events_due.push_back(deframe_beat(s_data));
            if (!s_valid || s_ready) begin
                if (rx_backlog.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
                    s_data  <= rx_backlog.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_error(input string what, input out_beat_t want,
                                input out_beat_t got);
        if (err_count < 10) begin
            $display("mismatch at %0t: %s", $time, what);
            $display("  want kind=%0d byte=%h idx=%0d len=%0d crc_seen=%b ovf_seen=%b",
                     want.event_kind, want.payload_byte, want.payload_index,
                     want.frame_length, want.crc_error_seen, want.overflow_seen);
            $display("  got  kind=%0d byte=%h idx=%0d len=%0d crc_seen=%b ovf_seen=%b",
                     got.event_kind, got.payload_byte, got.payload_index,
                     got.frame_length, got.crc_error_seen, got.overflow_seen);
        end
        err_count++;
    endtask

    // event sink: random back-pressure, compare against oldest expectation
    always @(posedge aclk) begin
        out_beat_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (events_due.size() == 0) begin
                    report_error("result with nothing expected", '0, m_data);
                end else begin
                    want = events_due.pop_front();
                    if (m_data.event_kind !== want.event_kind ||
                        m_data.payload_byte !== want.payload_byte ||
                        m_data.payload_index !== want.payload_index ||
                        m_data.frame_length !== want.frame_length ||
                        m_data.crc_error_seen !== want.crc_error_seen ||
                        m_data.overflow_seen !== want.overflow_seen)
                        report_error("result fields differ", want, m_data);
                end
            end
            m_ready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    // watchdog on cycles without any beat
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic push_item(input logic [7:0] d, input logic uerr);
        in_beat_t b;
        b.rx_byte        = d;
        b.upstream_error = uerr;
        rx_backlog.push_back(b);
        items_queued++;
    endtask

    // mostly uniform bytes, with the framing codes favored
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return regs_now.start_code;
            1:       return regs_now.end_code;
            2:       return regs_now.escape_code;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // frame_body plus its crc, escaped; optional bit error or cut followed by a loss flag
    task automatic send_frame(input bit corrupt, input int cut);
        logic [15:0] c;
        logic [7:0]  d;
        int          pos;
        c = regs_now.crc_init;
        foreach (frame_body[i])
            c = crc16_fold(c, frame_body[i], regs_now.crc_poly);
        frame_body.push_back(c[15:8]);
        frame_body.push_back(c[7:0]);
        if (corrupt) begin
            pos = $urandom_range(frame_body.size() - 1);
            frame_body[pos] = frame_body[pos] ^ (8'h01 << $urandom_range(7));
        end
        push_item(regs_now.start_code, 1'b0);
        for (int i = 0; i < frame_body.size() && (cut < 0 || i < cut); i++) begin
            d = frame_body[i];
            if (d == regs_now.start_code || d == regs_now.end_code ||
                d == regs_now.escape_code)
                push_item(regs_now.escape_code, 1'b0);
            push_item(d, 1'b0);
        end
        if (cut >= 0)
            push_item(pick_byte(), 1'b1);
        else
            push_item(regs_now.end_code, 1'b0);
        frame_body.delete();
    endtask

    // frames with random content, some line noise, bad crc and cut frames
    task automatic random_traffic(input int target, input bit close_noise);
        int base;
        int len;
        int roll;
        base = items_queued;
        while (items_queued - base < target) begin
            if ($urandom_range(99) < 15) begin
                repeat ($urandom_range(1, 8))
                    push_item(pick_byte(), $urandom_range(7) == 0);
                if (close_noise)
                    push_item(pick_byte(), 1'b1);
            end
            len = ($urandom_range(9) == 0) ? $urandom_range(21, 54) : $urandom_range(20);
            if (len > 0)
                frame_body.push_back(8'(len));
            for (int i = 1; i < len; i++)
                frame_body.push_back(pick_byte());
            roll = $urandom_range(99);
            send_frame(roll >= 70 && roll < 85, (roll >= 85) ? $urandom_range(len + 1) : -1);
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            CFG_CRC_POLY:    regs_now.crc_poly    = val;
            CFG_CRC_INIT:    regs_now.crc_init    = val;
            CFG_START_CODE:  regs_now.start_code  = val[7:0];
            CFG_END_CODE:    regs_now.end_code    = val[7:0];
            CFG_ESCAPE_CODE: regs_now.escape_code = val[7:0];
            default: ;
        endcase
    endtask

    // full register set; upper bits of the byte-wide codes carry junk
    task automatic write_regs(input logic [15:0] poly, input logic [15:0] init,
                              input logic [7:0] st, input logic [7:0] en,
                              input logic [7:0] es);
        cfg_write(CFG_CRC_POLY, poly);
        cfg_write(CFG_CRC_INIT, init);
        cfg_write(CFG_START_CODE, {8'($urandom_range(255)), st});
        cfg_write(CFG_END_CODE, {8'($urandom_range(255)), en});
        cfg_write(CFG_ESCAPE_CODE, {8'($urandom_range(255)), es});
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        @(posedge aclk);
        while (rx_backlog.size() != 0 || s_valid || events_due.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        logic [7:0] st;
        logic [7:0] en;
        logic [7:0] es;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed checks at reset register values
        pace = PACE_SLOW_RX;
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(8'hFF, 1'b1);
        // empty frame
        push_item(START_CODE_RST, 1'b0);
        push_item(END_CODE_RST, 1'b0);
        // every code escaped, the first one right after the start
        frame_body = '{END_CODE_RST, START_CODE_RST, ESCAPE_CODE_RST, 8'h00, 8'hFF};
        send_frame(1'b0, -1);
        // repeated start, then a restart in the middle of a frame
        push_item(START_CODE_RST, 1'b0);
        push_item(START_CODE_RST, 1'b0);
        push_item(8'h41, 1'b0);
        frame_body = '{8'h01, 8'h7F};
        send_frame(1'b0, -1);
        // bad crc, then byte loss in the middle of a frame
        frame_body = '{8'h02, 8'hC3};
        send_frame(1'b1, -1);
        frame_body = '{8'h03, 8'hAA, 8'h55};
        send_frame(1'b0, 3);
        wait_drained();

        write_regs(16'h8005, 16'h0000, 8'h7E, 8'h7F, 8'h7D);
        random_traffic(RAND_ITEMS, 1'b0);
        wait_drained();

        write_regs(16'hFFFF, 16'hFFFF, 8'h00, 8'hFF, 8'h80);
        random_traffic(RAND_ITEMS, 1'b0);
        wait_drained();

        pace = PACE_SLOW_TX;
        write_regs(16'h0000, 16'h1D0F, 8'hFF, 8'h00, 8'h01);
        random_traffic(RAND_ITEMS, 1'b0);
        wait_drained();

        // random distinct codes; a write to an unmapped index is dropped
        st = 8'($urandom_range(255));
        do en = 8'($urandom_range(255)); while (en == st);
        do es = 8'($urandom_range(255)); while (es == st || es == en);
        cfg_write(CFG_IDX_UNUSED, 16'($urandom_range(16'hFFFF)));
        write_regs(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)), st, en, es);
        random_traffic(RAND_ITEMS, 1'b0);
        wait_drained();

        // colliding codes: start shares the escape value, then start shares the end value
        pace = PACE_FULL;
        write_regs(16'h1021, 16'hFFFF, 8'h55, 8'h03, 8'h55);
        random_traffic(RAND_ITEMS, 1'b1);
        wait_drained();

        write_regs(16'h3D65, 16'h0000, 8'h7E, 8'h7E, 8'h7D);
        random_traffic(RAND_ITEMS, 1'b1);
        wait_drained();

        write_regs(CRC_POLY_RST, CRC_INIT_RST, START_CODE_RST, END_CODE_RST,
                   ESCAPE_CODE_RST);
        random_traffic(RAND_ITEMS, 1'b0);
        // frame filled to capacity, then a frame two bytes too long halts the block
        frame_body.push_back(8'd62);
        repeat (61) frame_body.push_back(pick_byte());
        send_frame(1'b0, -1);
        push_item(START_CODE_RST, 1'b0);
        repeat (FRAME_LEN + 2) push_item(8'h41, 1'b0);
        push_item(START_CODE_RST, 1'b1);
        push_item(START_CODE_RST, 1'b0);
        push_item(END_CODE_RST, 1'b0);
        wait_drained();

        repeat (8) @(posedge aclk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
